// ===== hdl/cflc_pkg.sv =====
// cflc_pkg: shared types, codes and sizes for the cosmetic filter line classifier
// no dependencies; used by cflc_step and cosmetic_filter_line_classifier

package cflc_pkg;

   localparam int MAX_LINE   = 4096;
   localparam int COUNT_BITS = 16;
   localparam int POS_W      = $clog2(MAX_LINE);
   localparam int OFF_W      = 12;
   localparam int TOTAL_W    = 16;
   localparam int NUM_CNT    = 5;

   localparam int CNT_RULE    = 0;
   localparam int CNT_COMMENT = 1;
   localparam int CNT_PROC    = 2;
   localparam int CNT_UNSUP   = 3;
   localparam int CNT_INVALID = 4;

   localparam logic [7:0] CH_NL      = 8'd10;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_QUEST   = 8'h3f;
   localparam logic [7:0] CH_DOLLAR  = 8'h24;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_BRACKET = 8'h5b;
   localparam logic [7:0] CH_TILDE   = 8'h7e;
   localparam logic [7:0] CH_COMMA   = 8'h2c;

   typedef enum logic [1:0] {
      PH_LEAD, PH_COMMENT, PH_SCAN, PH_SELECTOR
   } phase_type;

   typedef enum logic [2:0] {
      PR_NONE, PR_HASH, PR_AT, PR_QUEST, PR_DOLLAR, PR_PERCENT
   } progress_type;

   typedef enum logic [2:0] {
      MK_NONE, MK_HIDE, MK_EXCEPT, MK_PROC, MK_UNSUP
   } marker_type;

   typedef enum logic [1:0] {
      ES_EMPTY, ES_TILDE, ES_OK
   } entry_type;

   typedef enum logic [2:0] {
      CL_BLANK, CL_COMMENT, CL_PLAIN, CL_HIDE,
      CL_EXCEPT, CL_PROC, CL_UNSUP, CL_INVALID
   } class_type;

   typedef struct packed {
      phase_type    phase;
      progress_type progress;
      marker_type   kind;
      entry_type    entry;
      entry_type    entry_saved;
      logic         dom_bad;
      logic         dom_blank;
      logic         sel_seen;
      logic [POS_W-1:0] pos;
      logic [POS_W-1:0] moff;
      logic [POS_W-1:0] sfirst;
      logic [POS_W-1:0] slast;
   } state_type;

   typedef struct packed {
      logic               valid;
      class_type          cls;
      logic [POS_W-1:0]   moff;
      logic [POS_W-1:0]   sfirst;
      logic [POS_W-1:0]   slast;
      logic [NUM_CNT-1:0] bump;
      logic               last;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:       PH_LEAD,
      progress:    PR_NONE,
      kind:        MK_NONE,
      entry:       ES_EMPTY,
      entry_saved: ES_EMPTY,
      dom_bad:     1'b0,
      dom_blank:   1'b1,
      sel_seen:    1'b0,
      pos:         '0,
      moff:        '0,
      sfirst:      '0,
      slast:       '0
   };

endpackage

// ===== hdl/cflc_step.sv =====
// cflc_step: per-byte line parser, next line state and the line-end result
// depends on cflc_pkg

module cflc_step (
   input  cflc_pkg::state_type  cur,
   input  logic [7:0]           text_byte,
   input  logic                 final_byte,
   output cflc_pkg::state_type  nxt,
   output cflc_pkg::result_type res
);

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   cflc_pkg::state_type n;
   logic ws;
   logic scan;
   logic sel;
   logic do_dom;
   logic line_end;

   always_comb begin
      n        = cur;
      ws       = is_space(text_byte);
      scan     = 1'b0;
      sel      = 1'b0;
      do_dom   = 1'b0;
      line_end = (text_byte == cflc_pkg::CH_NL) || final_byte;

      if (text_byte != cflc_pkg::CH_NL) begin
         case (cur.phase)
            cflc_pkg::PH_LEAD: begin
               if (!ws) begin
                  if (text_byte == cflc_pkg::CH_BANG || text_byte == cflc_pkg::CH_BRACKET) begin
                     n.phase = cflc_pkg::PH_COMMENT;
                  end else begin
                     n.phase = cflc_pkg::PH_SCAN;
                     n.pos   = '0;
                     scan    = 1'b1;
                  end
               end
            end
            cflc_pkg::PH_SCAN:     scan = 1'b1;
            cflc_pkg::PH_SELECTOR: sel  = 1'b1;
            default: ;
         endcase
      end

      if (scan) begin
         case (cur.progress)
            cflc_pkg::PR_HASH: begin
               if (text_byte == cflc_pkg::CH_HASH) begin
                  n.kind = cflc_pkg::MK_HIDE;
               end else begin
                  do_dom = 1'b1;
                  case (text_byte)
                     cflc_pkg::CH_AT:      n.progress = cflc_pkg::PR_AT;
                     cflc_pkg::CH_QUEST:   n.progress = cflc_pkg::PR_QUEST;
                     cflc_pkg::CH_DOLLAR:  n.progress = cflc_pkg::PR_DOLLAR;
                     cflc_pkg::CH_PERCENT: n.progress = cflc_pkg::PR_PERCENT;
                     default:              n.progress = cflc_pkg::PR_NONE;
                  endcase
               end
            end
            cflc_pkg::PR_AT, cflc_pkg::PR_QUEST, cflc_pkg::PR_DOLLAR,
            cflc_pkg::PR_PERCENT: begin
               if (text_byte == cflc_pkg::CH_HASH) begin
                  case (cur.progress)
                     cflc_pkg::PR_AT:    n.kind = cflc_pkg::MK_EXCEPT;
                     cflc_pkg::PR_QUEST: n.kind = cflc_pkg::MK_PROC;
                     default:            n.kind = cflc_pkg::MK_UNSUP;
                  endcase
               end else begin
                  n.progress = cflc_pkg::PR_NONE;
                  do_dom     = 1'b1;
               end
            end
            default: begin
               n.progress = cflc_pkg::PR_NONE;
               if (text_byte == cflc_pkg::CH_HASH) begin
                  n.entry_saved = cur.entry;
                  n.moff        = cur.pos;
                  n.progress    = cflc_pkg::PR_HASH;
               end
               do_dom = 1'b1;
            end
         endcase

         // marker complete: selector follows
         if (n.kind != cflc_pkg::MK_NONE) begin
            n.phase     = cflc_pkg::PH_SELECTOR;
            n.progress  = cflc_pkg::PR_NONE;
            n.entry     = cur.entry_saved;
            n.dom_blank = (cur.moff == '0);
            if ((cur.moff != '0) && (cur.entry_saved != cflc_pkg::ES_OK)) begin
               n.dom_bad = 1'b1;
            end
         end

         // domain list entry tracking
         if (do_dom && !ws) begin
            n.dom_blank = 1'b0;
            if (text_byte == cflc_pkg::CH_COMMA) begin
               if (cur.entry != cflc_pkg::ES_OK) begin
                  n.dom_bad = 1'b1;
               end
               n.entry = cflc_pkg::ES_EMPTY;
            end else if (text_byte == cflc_pkg::CH_TILDE) begin
               n.entry = (cur.entry == cflc_pkg::ES_EMPTY) ? cflc_pkg::ES_TILDE
                                                           : cflc_pkg::ES_OK;
            end else begin
               n.entry = cflc_pkg::ES_OK;
            end
         end
      end

      if (sel && !ws) begin
         if (!cur.sel_seen) begin
            n.sel_seen = 1'b1;
            n.sfirst   = cur.pos;
         end
         n.slast = cur.pos;
      end

      if ((scan || sel) && (n.pos != cflc_pkg::POS_W'(cflc_pkg::MAX_LINE - 1))) begin
         n.pos = n.pos + 1'b1;
      end
   end

   always_comb begin
      res        = '0;
      res.valid  = line_end;
      res.last   = final_byte;
      res.cls    = cflc_pkg::CL_BLANK;
      case (n.phase)
         cflc_pkg::PH_COMMENT: begin
            res.cls                        = cflc_pkg::CL_COMMENT;
            res.bump[cflc_pkg::CNT_COMMENT] = 1'b1;
         end
         cflc_pkg::PH_SCAN: res.cls = cflc_pkg::CL_PLAIN;
         cflc_pkg::PH_SELECTOR: begin
            res.moff   = n.moff;
            res.sfirst = n.sfirst;
            res.slast  = n.slast;
            if (!n.sel_seen) begin
               res.cls    = cflc_pkg::CL_INVALID;
               res.sfirst = '0;
               res.slast  = '0;
            end else if (n.kind == cflc_pkg::MK_PROC) begin
               res.cls = cflc_pkg::CL_PROC;
            end else if (n.kind == cflc_pkg::MK_UNSUP) begin
               res.cls = cflc_pkg::CL_UNSUP;
            end else if (n.dom_bad) begin
               res.cls = cflc_pkg::CL_INVALID;
            end else if (n.kind == cflc_pkg::MK_EXCEPT) begin
               res.cls = cflc_pkg::CL_EXCEPT;
            end else begin
               res.cls = cflc_pkg::CL_HIDE;
            end
            case (res.cls)
               cflc_pkg::CL_HIDE, cflc_pkg::CL_EXCEPT:
                  res.bump[cflc_pkg::CNT_RULE] = 1'b1;
               cflc_pkg::CL_PROC:  res.bump[cflc_pkg::CNT_PROC]    = 1'b1;
               cflc_pkg::CL_UNSUP: res.bump[cflc_pkg::CNT_UNSUP]   = 1'b1;
               default:            res.bump[cflc_pkg::CNT_INVALID] = 1'b1;
            endcase
         end
         default: ;
      endcase
      res.bump = line_end ? res.bump : '0;
   end

   assign nxt = line_end ? cflc_pkg::STATE_RESET : n;

endmodule

// ===== hdl/cosmetic_filter_line_classifier.sv =====
// cosmetic_filter_line_classifier: top level, input register, line state,
// saturating class counters and result register; depends on cflc_pkg, cflc_step
//
//   channel  ports   direction  beat
//   req      req_*   in         one text byte and its final flag
//   rsp      rsp_*   out        one line result at each line end
//
// one byte per cycle while the result is not stalled: a beat is registered in
// the input register, then the step logic updates the line state and loads the
// result register. reset clears state, counters and valids.
// a stalled result holds the step; the input register still takes one beat.

module cosmetic_filter_line_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_text_byte,
   input  logic        req_final_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_line_class,
   output logic [11:0] rsp_marker_offset,
   output logic [11:0] rsp_selector_first,
   output logic [11:0] rsp_selector_last,
   output logic [15:0] rsp_rule_total,
   output logic [15:0] rsp_comment_total,
   output logic [15:0] rsp_procedural_total,
   output logic [15:0] rsp_unsupported_total,
   output logic [15:0] rsp_invalid_total,
   output logic        rsp_end_of_text
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_final_ff;
   logic       step_go;

   cflc_pkg::state_type  state_ff, state_in, step_nxt;
   cflc_pkg::result_type step_res;

   logic [cflc_pkg::COUNT_BITS-1:0] cnt_ff [cflc_pkg::NUM_CNT];
   logic [cflc_pkg::COUNT_BITS-1:0] cnt_in [cflc_pkg::NUM_CNT];
   logic [cflc_pkg::COUNT_BITS-1:0] cnt_new [cflc_pkg::NUM_CNT];

   logic                        out_valid_ff, out_valid_in;
   cflc_pkg::class_type         out_cls_ff;
   logic [cflc_pkg::OFF_W-1:0]  out_moff_ff, out_sfirst_ff, out_slast_ff;
   logic [cflc_pkg::TOTAL_W-1:0] out_tot_ff [cflc_pkg::NUM_CNT];
   logic                        out_last_ff;

   assign step_go   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !step_go;

   cflc_step u_step (
      .cur        (state_ff),
      .text_byte  (in_byte_ff),
      .final_byte (in_final_ff),
      .nxt        (step_nxt),
      .res        (step_res)
   );

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      state_in     = state_ff;
      out_valid_in = out_valid_ff;
      for (int i = 0; i < cflc_pkg::NUM_CNT; i++) begin
         cnt_new[i] = cnt_ff[i];
         if (step_res.bump[i] && (cnt_ff[i] != '1)) begin
            cnt_new[i] = cnt_ff[i] + 1'b1;
         end
         cnt_in[i] = cnt_ff[i];
      end
      if (step_go) begin
         out_valid_in = in_valid_ff && step_res.valid;
         if (in_valid_ff) begin
            state_in = step_nxt;
            for (int i = 0; i < cflc_pkg::NUM_CNT; i++) begin
               cnt_in[i] = (step_res.valid && step_res.last) ? '0 : cnt_new[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= cflc_pkg::STATE_RESET;
         for (int i = 0; i < cflc_pkg::NUM_CNT; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         for (int i = 0; i < cflc_pkg::NUM_CNT; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff  <= req_text_byte;
         in_final_ff <= req_final_byte;
      end
      if (step_go && in_valid_ff && step_res.valid) begin
         out_cls_ff    <= step_res.cls;
         out_moff_ff   <= cflc_pkg::OFF_W'(step_res.moff);
         out_sfirst_ff <= cflc_pkg::OFF_W'(step_res.sfirst);
         out_slast_ff  <= cflc_pkg::OFF_W'(step_res.slast);
         out_last_ff   <= step_res.last;
         for (int i = 0; i < cflc_pkg::NUM_CNT; i++) begin
            out_tot_ff[i] <= cflc_pkg::TOTAL_W'(cnt_new[i]);
         end
      end
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_line_class        = out_cls_ff;
   assign rsp_marker_offset     = out_moff_ff;
   assign rsp_selector_first    = out_sfirst_ff;
   assign rsp_selector_last     = out_slast_ff;
   assign rsp_rule_total        = out_tot_ff[cflc_pkg::CNT_RULE];
   assign rsp_comment_total     = out_tot_ff[cflc_pkg::CNT_COMMENT];
   assign rsp_procedural_total  = out_tot_ff[cflc_pkg::CNT_PROC];
   assign rsp_unsupported_total = out_tot_ff[cflc_pkg::CNT_UNSUP];
   assign rsp_invalid_total     = out_tot_ff[cflc_pkg::CNT_INVALID];
   assign rsp_end_of_text       = out_last_ff;

endmodule

// ===== verif/tb_top.sv =====
// tb_top: self-checking testbench for cosmetic_filter_line_classifier
// depends on cflc_pkg and the block; a scoreboard class predicts each line result
// from the accepted byte stream, tasks drive random line text with idling and stalls

module tb_top;
   import cflc_pkg::*;

   localparam int RANDOM_BYTES = 1420;
   localparam int IDLE_LIMIT   = 2000;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      class_type                       cls;
      logic [OFF_W-1:0]                moff;
      logic [OFF_W-1:0]                sfirst;
      logic [OFF_W-1:0]                slast;
      logic [NUM_CNT-1:0][TOTAL_W-1:0] totals;
      logic                            eot;
   } line_result;

   typedef enum int {STALL_NONE, STALL_SPARSE, STALL_COMB, STALL_HEAVY} stall_mode_type;

   class line_scoreboard;
      phase_type             ln_phase;
      progress_type          prog;
      marker_type            kind;
      entry_type             entry;
      entry_type             entry_saved;
      bit                    dom_bad;
      bit                    dom_blank;
      bit                    sel_seen;
      logic [POS_W-1:0]      pos;
      logic [POS_W-1:0]      moff;
      logic [POS_W-1:0]      sfirst;
      logic [POS_W-1:0]      slast;
      logic [COUNT_BITS-1:0] totals [NUM_CNT];
      line_result            expected_lines [$];
      int                    errors;

      function new();
         errors = 0;
         clear_list();
      endfunction

      function void clear_line();
         ln_phase    = PH_LEAD;
         prog        = PR_NONE;
         kind        = MK_NONE;
         entry       = ES_EMPTY;
         entry_saved = ES_EMPTY;
         dom_bad     = 1'b0;
         dom_blank   = 1'b1;
         sel_seen    = 1'b0;
         pos         = '0;
         moff        = '0;
         sfirst      = '0;
         slast       = '0;
      endfunction

      function void clear_list();
         clear_line();
         foreach (totals[i]) totals[i] = '0;
      endfunction

      function bit is_ws(logic [7:0] b);
         return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
      endfunction

      function void bump(int idx);
         if (totals[idx] != '1) totals[idx]++;
      endfunction

      function void domain_byte(logic [7:0] b);
         if (is_ws(b)) return;
         dom_blank = 1'b0;
         if (b == CH_COMMA) begin
            if (entry != ES_OK) dom_bad = 1'b1;
            entry = ES_EMPTY;
         end else if (b == CH_TILDE) begin
            entry = (entry == ES_EMPTY) ? ES_TILDE : ES_OK;
         end else begin
            entry = ES_OK;
         end
      endfunction

      function void marker_done(marker_type k);
         ln_phase  = PH_SELECTOR;
         kind      = k;
         prog      = PR_NONE;
         entry     = entry_saved;
         dom_blank = (moff == 0);
         if (!dom_blank && entry != ES_OK) dom_bad = 1'b1;
      endfunction

      function void scan_byte(logic [7:0] b);
         case (prog)
            PR_HASH: begin
               if (b == CH_HASH) begin
                  marker_done(MK_HIDE);
                  return;
               end
               case (b)
                  CH_AT:      prog = PR_AT;
                  CH_QUEST:   prog = PR_QUEST;
                  CH_DOLLAR:  prog = PR_DOLLAR;
                  CH_PERCENT: prog = PR_PERCENT;
                  default:    prog = PR_NONE;
               endcase
               domain_byte(b);
            end
            PR_AT, PR_QUEST, PR_DOLLAR, PR_PERCENT: begin
               if (b == CH_HASH) begin
                  case (prog)
                     PR_AT:    marker_done(MK_EXCEPT);
                     PR_QUEST: marker_done(MK_PROC);
                     default:  marker_done(MK_UNSUP);
                  endcase
                  return;
               end
               prog = PR_NONE;
               domain_byte(b);
            end
            default: begin
               prog = PR_NONE;
               if (b == CH_HASH) begin
                  entry_saved = entry;
                  moff        = pos;
                  prog        = PR_HASH;
               end
               domain_byte(b);
            end
         endcase
      endfunction

      function void content_byte(logic [7:0] b);
         bit ws;
         ws = is_ws(b);
         if (ln_phase == PH_LEAD) begin
            if (ws) return;
            if (b == CH_BANG || b == CH_BRACKET) begin
               ln_phase = PH_COMMENT;
               return;
            end
            ln_phase = PH_SCAN;
            pos      = '0;
         end
         if (ln_phase == PH_SCAN) begin
            scan_byte(b);
         end else if (ln_phase == PH_SELECTOR) begin
            if (!ws) begin
               if (!sel_seen) begin
                  sel_seen = 1'b1;
                  sfirst   = pos;
               end
               slast = pos;
            end
         end else begin
            return;
         end
         if (pos < MAX_LINE - 1) pos++;
      endfunction

      // one accepted beat; a line end queues the predicted result
      function void take_byte(logic [7:0] b, logic fin);
         line_result r;
         if (b != CH_NL) content_byte(b);
         if (b != CH_NL && !fin) return;
         r     = '0;
         r.cls = CL_BLANK;
         case (ln_phase)
            PH_COMMENT: begin
               r.cls = CL_COMMENT;
               bump(CNT_COMMENT);
            end
            PH_SCAN: r.cls = CL_PLAIN;
            PH_SELECTOR: begin
               r.moff   = moff;
               r.sfirst = sfirst;
               r.slast  = slast;
               if (!sel_seen) begin
                  r.cls    = CL_INVALID;
                  r.sfirst = '0;
                  r.slast  = '0;
               end else if (kind == MK_PROC) begin
                  r.cls = CL_PROC;
               end else if (kind == MK_UNSUP) begin
                  r.cls = CL_UNSUP;
               end else if (dom_bad) begin
                  r.cls = CL_INVALID;
               end else if (kind == MK_EXCEPT) begin
                  r.cls = CL_EXCEPT;
               end else begin
                  r.cls = CL_HIDE;
               end
               case (r.cls)
                  CL_HIDE, CL_EXCEPT: bump(CNT_RULE);
                  CL_PROC:            bump(CNT_PROC);
                  CL_UNSUP:           bump(CNT_UNSUP);
                  default:            bump(CNT_INVALID);
               endcase
            end
            default: ;
         endcase
         for (int i = 0; i < NUM_CNT; i++) r.totals[i] = TOTAL_W'(totals[i]);
         r.eot = fin;
         expected_lines = {expected_lines, r};
         if (fin) clear_list();
         else clear_line();
      endfunction

      function void check_line(line_result got);
         line_result want;
         if (expected_lines.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("unexpected line result: class %0d moff %0d sel %0d..%0d eot %0d",
                        got.cls, got.moff, got.sfirst, got.slast, got.eot);
            return;
         end
         want = expected_lines.pop_front();
         if (got.cls !== want.cls || got.moff !== want.moff || got.sfirst !== want.sfirst ||
             got.slast !== want.slast || got.totals !== want.totals || got.eot !== want.eot) begin
            errors++;
            if (errors <= REPORT_MAX) begin
               $display("line mismatch, expected: class %0d moff %0d sel %0d..%0d eot %0d tot %h",
                        want.cls, want.moff, want.sfirst, want.slast, want.eot, want.totals);
               $display("                 actual: class %0d moff %0d sel %0d..%0d eot %0d tot %h",
                        got.cls, got.moff, got.sfirst, got.slast, got.eot, got.totals);
            end
         end
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction
   endclass

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_text_byte  = '0;
   logic        req_final_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [2:0]  rsp_line_class;
   logic [11:0] rsp_marker_offset;
   logic [11:0] rsp_selector_first;
   logic [11:0] rsp_selector_last;
   logic [15:0] rsp_rule_total;
   logic [15:0] rsp_comment_total;
   logic [15:0] rsp_procedural_total;
   logic [15:0] rsp_unsupported_total;
   logic [15:0] rsp_invalid_total;
   logic        rsp_end_of_text;

   line_scoreboard sb;
   line_result     seen;
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             bytes_sent = 0;
   logic [7:0]     line_bytes [$];

   cosmetic_filter_line_classifier u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_text_byte         (req_text_byte),
      .req_final_byte        (req_final_byte),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_line_class        (rsp_line_class),
      .rsp_marker_offset     (rsp_marker_offset),
      .rsp_selector_first    (rsp_selector_first),
      .rsp_selector_last     (rsp_selector_last),
      .rsp_rule_total        (rsp_rule_total),
      .rsp_comment_total     (rsp_comment_total),
      .rsp_procedural_total  (rsp_procedural_total),
      .rsp_unsupported_total (rsp_unsupported_total),
      .rsp_invalid_total     (rsp_invalid_total),
      .rsp_end_of_text       (rsp_end_of_text)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // result side: check each accepted beat, stall on a changing pattern
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_mode <= STALL_NONE;
         mode_left  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen.cls                 = class_type'(rsp_line_class);
            seen.moff                = rsp_marker_offset;
            seen.sfirst              = rsp_selector_first;
            seen.slast               = rsp_selector_last;
            seen.totals[CNT_RULE]    = rsp_rule_total;
            seen.totals[CNT_COMMENT] = rsp_comment_total;
            seen.totals[CNT_PROC]    = rsp_procedural_total;
            seen.totals[CNT_UNSUP]   = rsp_unsupported_total;
            seen.totals[CNT_INVALID] = rsp_invalid_total;
            seen.eot                 = rsp_end_of_text;
            sb.check_line(seen);
         end
         if (mode_left == 0) begin
            stall_mode <= stall_mode_type'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 300);
         end else begin
            mode_left <= mode_left - 1;
         end
         case (stall_mode)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_COMB:   rsp_stall <= ((mode_left % 9) < 4);
            default:      rsp_stall <= ($urandom_range(0, 9) < 7);
         endcase
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic fin);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                  : $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid      <= 1'b1;
      req_text_byte  <= b;
      req_final_byte <= fin;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.take_byte(b, fin);
      burst_left--;
      bytes_sent++;
   endtask

   // sends the built line; the list's final flag goes on the newline or the last text byte
   task automatic send_line(input bit fin);
      int n;
      bit on_text;
      n       = line_bytes.size();
      on_text = fin && n != 0 && ($urandom_range(0, 1) != 0);
      for (int i = 0; i < n; i++) push_byte(line_bytes[i], on_text && i == n - 1);
      if (!on_text) push_byte(CH_NL, fin);
      line_bytes.delete();
   endtask

   function automatic logic [7:0] pick(string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CH_NL);
      return b;
   endfunction

   function automatic void add_byte(logic [7:0] b);
      line_bytes = {line_bytes, b};
   endfunction

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void add_ws(int most);
      repeat ($urandom_range(0, most)) add_byte(pick("\t\013\014\015 "));
   endfunction

   function automatic void add_word();
      repeat ($urandom_range(1, 6)) add_byte(pick("abcxyz.-09"));
   endfunction

   function automatic void build_line();
      int roll;
      int entries;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         add_ws(3);
      end else if (roll < 16) begin
         add_ws(2);
         add_str(($urandom_range(0, 1) != 0) ? "!" : "[");
         repeat ($urandom_range(0, 10)) add_byte(rand_byte());
      end else if (roll < 26) begin
         add_ws(2);
         repeat ($urandom_range(1, 12)) add_byte(pick("abc/|^$*.=&?019"));
         add_ws(2);
      end else if (roll < 36) begin
         repeat ($urandom_range(1, 14))
            add_byte(($urandom_range(0, 1) != 0) ? pick("#@?$%,~ !") : rand_byte());
      end else if (roll < 44) begin
         // broken marker
         add_word();
         add_str("#");
         if ($urandom_range(0, 2) != 0) add_byte(pick("@?$%x,"));
         if ($urandom_range(0, 1) != 0) add_word();
      end else begin
         add_ws(2);
         entries = $urandom_range(0, 3);
         for (int i = 0; i < entries; i++) begin
            if (i != 0) add_str(",");
            add_ws(1);
            case ($urandom_range(0, 9))
               0: ;
               1: add_str("~");
               2, 3: begin
                  add_str("~");
                  add_word();
               end
               default: add_word();
            endcase
            add_ws(1);
         end
         if ($urandom_range(0, 15) == 0) add_str(",");
         case ($urandom_range(0, 7))
            0, 1, 2: add_str("##");
            3, 4:    add_str("#@#");
            5:       add_str("#?#");
            6:       add_str("#$#");
            default: add_str("#%#");
         endcase
         add_ws(2);
         if ($urandom_range(0, 9) != 0)
            repeat ($urandom_range(1, 10))
               add_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(128, 255))
                                                    : pick(".#ab[]=-:>* "));
         add_ws(2);
      end
   endfunction

   initial begin
      int start;
      int lines;
      bit last_line;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed lines
      send_line(1'b0);
      add_str("!");
      send_line(1'b0);
      add_str("a#");
      send_line(1'b0);
      add_str("##b");
      send_line(1'b0);
      add_str("#@#b");
      send_line(1'b0);
      add_str("#?#");
      send_line(1'b0);
      add_str("#$#b");
      send_line(1'b0);
      // final beat inside a line, high byte as selector
      push_byte(CH_HASH, 1'b0);
      push_byte(CH_PERCENT, 1'b0);
      push_byte(CH_HASH, 1'b0);
      push_byte(8'hff, 1'b1);

      start = bytes_sent;
      while (bytes_sent - start < RANDOM_BYTES) begin
         lines = $urandom_range(1, 30);
         for (int i = 0; i < lines; i++) begin
            build_line();
            last_line = (i == lines - 1) ||
                        (bytes_sent - start + line_bytes.size() + 1 >= RANDOM_BYTES);
            send_line(last_line);
            if (bytes_sent - start >= RANDOM_BYTES) break;
         end
      end
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
